[src/ufj_pkg.sv]
// ufj_pkg: shared types and constants of the union-find join engine.
// Used by the channel interfaces, the parent store and the top level.
// No dependencies.
package ufj_pkg;

  // Node count and node index width
  localparam int NODES  = 65536;
  localparam int NODE_W = 16;

  typedef logic [NODE_W-1:0] node_t;

  // Node count widened by one bit for range checks on incoming indexes
  localparam logic [NODE_W:0] NODES_EXT = (NODE_W+1)'(NODES);

  // Access request from the sequencer to the parent store
  typedef struct packed {
    logic  rd_en;
    node_t rd_addr;
    logic  wr_en;
    node_t wr_addr;
    node_t wr_data;
  } store_req_t;

endpackage

[src/ufj_ifs.sv]
// Channel interfaces of the union-find join engine: join requests and results.
// Depends on ufj_pkg.
interface ufj_in_if;
  import ufj_pkg::*;

  logic  valid;
  logic  ready;
  node_t node_a;
  node_t node_b;

  modport source (output valid, output node_a, output node_b, input ready);
  modport sink   (input valid, input node_a, input node_b, output ready);
endinterface

interface ufj_out_if;
  logic valid;
  logic ready;
  logic merged;

  modport source (output valid, output merged, input ready);
  modport sink   (input valid, input merged, output ready);
endinterface

[src/ufj_parent_store.sv]
// ufj_parent_store: parent pointer memory, one read and one write per cycle,
// read data registered. Runs the identity fill after reset. Depends on ufj_pkg.
module ufj_parent_store (
  input  logic                clk,
  input  logic                rst_n,
  input  ufj_pkg::store_req_t req,
  output ufj_pkg::node_t      rd_data,
  output logic                ready
);
  import ufj_pkg::*;

  node_t mem [NODES];
  node_t rd_data_r;
  logic  clearing_r;
  node_t clr_idx_r;

  logic  wr_en;
  node_t wr_addr;
  node_t wr_data;

  // Fill pass: entry i gets i, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + node_t'(1);
      if (clr_idx_r == node_t'(NODES - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Write port select: fill pass owns the port while running
  always_comb begin
    if (clearing_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = clr_idx_r;
    end else begin
      wr_en   = req.wr_en;
      wr_addr = req.wr_addr;
      wr_data = req.wr_data;
    end
  end

  // Memory array: read returns the old contents on an address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;
  assign ready   = !clearing_r;

endmodule

[src/union_find_join.sv]
// union_find_join: disjoint-set join engine with path compression.
// Depends on ufj_pkg, ufj_ifs (ufj_in_if, ufj_out_if) and ufj_parent_store.
//
// Usage:
//   in_ch carries a join request (node_a, node_b); a transfer happens when
//   valid and ready are both high. out_ch carries one result (merged) per
//   request, in request order. merged is 1 when the two nodes were in
//   different sets; the root of node_a is then linked under the root of
//   node_b. Both find paths are compressed onto their roots.
//   Each request walks from node_a to its root, re-walks that path to point
//   every node on it at the root, does the same for node_b, then links the
//   two roots. Walk and re-walk are both paced by the single read port of
//   the parent memory. One request is in flight at a time; compression keeps
//   paths short. Indexes at or beyond the node count return merged = 0 and
//   leave the table unchanged.
//   Reset: the parent memory is filled with the identity, one entry per
//   cycle, so in_ch.ready stays low after reset is released until the fill
//   is done.
//   Stall: a result waits in the output register while out_ch.ready is low;
//   the next request is still taken and runs up to its result, then holds.
module union_find_join (
  input logic      clk,
  input logic      rst_n,
  ufj_in_if.sink   in_ch,
  ufj_out_if.source out_ch
);
  import ufj_pkg::*;

  // Sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_FIND  = 3'd2;
  localparam logic [2:0] ST_COMP  = 3'd3;
  localparam logic [2:0] ST_LINK  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       phase_r, phase_nxt;     // 0: node_a path, 1: node_b path
  node_t      a_r, a_nxt;
  node_t      b_r, b_nxt;
  node_t      cur_r, cur_nxt;
  node_t      ra_r, ra_nxt;
  node_t      rb_r, rb_nxt;
  logic       pend_r, pend_nxt;       // result waiting for the output register
  logic       out_valid_r, out_valid_nxt;
  logic       merged_r, merged_nxt;

  store_req_t req;
  node_t      rd_data;
  logic       store_ready;

  node_t      start_node;
  node_t      root_sel;
  logic       go_next;
  logic       out_of_range;

  ufj_parent_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_data (rd_data),
    .ready   (store_ready)
  );

  assign start_node   = phase_r ? b_r : a_r;
  assign root_sel     = phase_r ? rb_r : ra_r;
  assign out_of_range = ({1'b0, in_ch.node_a} >= NODES_EXT) ||
                        ({1'b0, in_ch.node_b} >= NODES_EXT);
  assign in_ch.ready  = (state_r == ST_IDLE);

  // Sequencer: walk to the root, re-walk to compress, then link
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    cur_nxt       = cur_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    merged_nxt    = merged_r;
    req           = '0;
    go_next       = 1'b0;

    // Output register drains on a transfer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        if (store_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          a_nxt = in_ch.node_a;
          b_nxt = in_ch.node_b;
          if (out_of_range) begin
            pend_nxt  = 1'b0;
            state_nxt = ST_DONE;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = in_ch.node_a;
            cur_nxt     = in_ch.node_a;
            phase_nxt   = 1'b0;
            state_nxt   = ST_FIND;
          end
        end
      end
      ST_FIND: begin
        if (rd_data == cur_r) begin
          // Root reached
          if (phase_r) begin
            rb_nxt = cur_r;
          end else begin
            ra_nxt = cur_r;
          end
          if (start_node == cur_r) begin
            go_next = 1'b1;
          end else begin
            req.rd_en   = 1'b1;
            req.rd_addr = start_node;
            cur_nxt     = start_node;
            state_nxt   = ST_COMP;
          end
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = rd_data;
          cur_nxt     = rd_data;
        end
      end
      ST_COMP: begin
        // Point the visited node at the root, fetch the following one
        req.wr_en   = 1'b1;
        req.wr_addr = cur_r;
        req.wr_data = root_sel;
        if (rd_data == root_sel) begin
          go_next = 1'b1;
        end else begin
          req.rd_en   = 1'b1;
          req.rd_addr = rd_data;
          cur_nxt     = rd_data;
        end
      end
      ST_LINK: begin
        pend_nxt    = (ra_r != rb_r);
        req.wr_en   = (ra_r != rb_r);
        req.wr_addr = ra_r;
        req.wr_data = rb_r;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          merged_nxt    = pend_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // End of one path: start on node_b, or go link
    if (go_next) begin
      if (!phase_r) begin
        phase_nxt   = 1'b1;
        req.rd_en   = 1'b1;
        req.rd_addr = b_r;
        cur_nxt     = b_r;
        state_nxt   = ST_FIND;
      end else begin
        state_nxt = ST_LINK;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    cur_r    <= cur_nxt;
    ra_r     <= ra_nxt;
    rb_r     <= rb_nxt;
    pend_r   <= pend_nxt;
    merged_r <= merged_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.merged = merged_r;

  // Requests are only taken once the identity fill has finished
  a_accept_after_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> store_ready)
    else $error("request accepted during parent fill");

  // A finished result reaches the output register when it is free
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded into free output register");

  // Link writes exactly when the roots differ, and the result says so
  a_link_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LINK) |-> ((req.wr_en == (ra_r != rb_r)) && (pend_nxt == req.wr_en)))
    else $error("link write does not match root comparison");

  // No table writes while idle or waiting to hand off a result
  a_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE) |-> !req.wr_en)
    else $error("parent table written outside a join");

endmodule

[tb/union_find_join_tb.sv]
// union_find_join_tb: self-checking bench for the union-find join engine.
// A scoreboard keeps its own parent table and predicts merged per join.
// Depends on ufj_pkg, ufj_ifs and union_find_join.
module union_find_join_tb;
  import ufj_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RANDOM_JOINS = 1250;
  localparam int IDLE_LIMIT   = 300000;  // several times the clear pass after reset
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int POOL_SPAN    = 64;

  // Disjoint-set predictor and in-order store of expected merged flags
  class dsu_scoreboard;
    node_t parent_of [NODES];
    bit    merged_q [$];
    int    error_count;

    function new();
      for (int i = 0; i < NODES; i++) parent_of[i] = node_t'(i);
      error_count = 0;
    endfunction

    // Walk to the root, then point every node on the path at it
    function node_t find_root(node_t n);
      node_t       r;
      node_t       cur;
      node_t       nxt;
      int unsigned steps;
      r = n;
      steps = 0;
      while (parent_of[r] != r && steps < NODES) begin
        r = parent_of[r];
        steps++;
      end
      cur = n;
      steps = 0;
      while (cur != r && steps < NODES) begin
        nxt = parent_of[cur];
        parent_of[cur] = r;
        cur = nxt;
        steps++;
      end
      return r;
    endfunction

    // Accepted join request: update the table and queue the flag
    function void note_join(node_t a, node_t b);
      node_t ra;
      node_t rb;
      bit    m;
      m = 1'b0;
      if ({1'b0, a} < NODES_EXT && {1'b0, b} < NODES_EXT) begin
        ra = find_root(a);
        rb = find_root(b);
        if (ra != rb) begin
          parent_of[ra] = rb;
          m = 1'b1;
        end
      end
      merged_q = {merged_q, m};
    endfunction

    // Accepted result: compare against the oldest expectation
    function void check_merged(logic merged);
      bit m;
      if (merged_q.size() == 0) begin
        $error("merged: no result expected, got %0b", merged);
        error_count++;
        return;
      end
      m = merged_q.pop_front();
      if (merged !== m) begin
        $error("merged: expected %0b, got %0b", m, merged);
        error_count++;
      end
    endfunction

    function int outstanding();
      return merged_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ufj_in_if  in_if ();
  ufj_out_if out_if ();

  union_find_join u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  dsu_scoreboard sb = new();

  bit          quiet    = 1'b0;  // both sides run without gaps while set
  bit          hold_req = 1'b0;  // asks the receiver for one long hold-off
  int unsigned idle_cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet)  return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one join request and wait for its transfer
  task automatic send_join(input node_t a, input node_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.node_a <= a;
    in_if.node_b <= b;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stop offering until every expected result has come back
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Monitor: transfers on both channels, idle count for the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_join(in_if.node_a, in_if.node_b);
      if (out_if.valid && out_if.ready) sb.check_merged(out_if.merged);
    end
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // Watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_if.ready <= 1'b1;
      end
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Sender and end of run
  initial begin
    node_t a;
    node_t b;
    node_t seg_base;
    node_t chain_cur;
    int unsigned r;

    in_if.valid  <= 1'b0;
    in_if.node_a <= '0;
    in_if.node_b <= '0;
    rst_n        <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: index extremes, repeats, alternating bits
    send_join(16'h0000, 16'h0000);
    send_join(16'hFFFF, 16'hFFFF);
    send_join(16'h0000, 16'hFFFF);
    send_join(16'hFFFF, 16'h0000);
    send_join(16'h0000, 16'hFFFF);
    send_join(16'h5555, 16'hAAAA);
    // Build a 16-hop chain, then walk and compress it from the bottom
    for (int i = 100; i < 116; i++) send_join(node_t'(i), node_t'(i + 1));
    send_join(16'd100, 16'd0);
    send_join(16'd116, 16'd100);
    send_join(16'd108, 16'd108);

    // Random: mostly joins inside a small window so sets grow deep
    seg_base  = node_t'($urandom_range(0, NODES - POOL_SPAN - 1));
    chain_cur = seg_base;
    for (int n = 0; n < RANDOM_JOINS; n++) begin
      if (n % 100 == 0) begin
        seg_base  = node_t'($urandom_range(0, NODES - POOL_SPAN - 1));
        chain_cur = seg_base;
      end
      if (n == 300) hold_req = 1'b1;
      if (n == 700) wait_drained();
      quiet = (n >= 900 && n < 1000);

      r = $urandom_range(0, 99);
      if (r < 60) begin
        a = seg_base + node_t'($urandom_range(0, POOL_SPAN - 1));
        b = seg_base + node_t'($urandom_range(0, POOL_SPAN - 1));
      end else if (r < 72) begin
        // extend a chain: each link hangs the current node's root under the next node's root
        a = chain_cur;
        b = chain_cur + 1'b1;
        chain_cur = (chain_cur - seg_base < POOL_SPAN - 2) ? b : seg_base;
      end else if (r < 78) begin
        a = seg_base + node_t'($urandom_range(0, POOL_SPAN - 1));
        b = a;
      end else begin
        a = node_t'($urandom_range(0, NODES - 1));
        b = node_t'($urandom_range(0, NODES - 1));
      end
      send_join(a, b);
    end

    // Drain and settle
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.error_count == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/ufj_pkg.sv
src/ufj_ifs.sv
src/ufj_parent_store.sv
src/union_find_join.sv
tb/union_find_join_tb.sv
